### hdl/nearest_center_box_iou_match_defines.svh
// Assertion macros for the box match block
`ifndef NEAREST_CENTER_BOX_IOU_MATCH_DEFINES_SVH
`define NEAREST_CENTER_BOX_IOU_MATCH_DEFINES_SVH

// check in the same cycle
`define NCBIM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// check in the next cycle
`define NCBIM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ncbim_pkg.sv
`timescale 1ns / 1ps
package ncbim_pkg;

  localparam int MAX_TRUTH_BOXES = 64;
  localparam int COORD_BITS      = 13;

  localparam int IDX_W    = (MAX_TRUTH_BOXES > 1) ? $clog2(MAX_TRUTH_BOXES) : 1;
  localparam int COUNT_W  = $clog2(MAX_TRUTH_BOXES + 1);
  localparam int CENTER_W = 12;
  localparam int CLASS_W  = 8;
  localparam int TAG_W    = 2 * CENTER_W + CLASS_W;
  localparam int CORNER_W = 4 * COORD_BITS;
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int UNI_W    = PROD_W + 2;
  localparam int IOU_W    = 16;
  localparam int QCNT_W   = $clog2(IOU_W);
  localparam int LIMIT_W  = 14;
  localparam int DIST_W   = CENTER_W + 1;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(9999);
  localparam logic [IOU_W-1:0]   IOU_MAX     = {IOU_W{1'b1}};

  localparam logic REG_SEL_LIMIT = 1'b0;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_MATCH = 2'd2;

endpackage

### hdl/nearest_center_box_iou_match.sv
`timescale 1ns / 1ps
// Nearest-center box match with IoU. A load into a full table is dropped. A match item
// stalls the input while the table (up to 64 stored boxes) is read one entry per cycle
// through its single read port; then one shared multiplier forms the overlap and the two
// areas and a restoring divider produces the 16 fraction bits one per cycle. When no box
// lies within the distance limit the multiplier and divider are skipped, and the divider
// is skipped when the union is not positive or the overlap fills it. The finished result
// sits in an output register, so the input is open again while it waits to be taken; a
// later match that finishes while that register is still held keeps the input stalled
// until the waiting result is taken.
module nearest_center_box_iou_match (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      item_valid,
  output logic                                      item_stall,
  input  logic [1:0]                                operation,
  input  logic [ncbim_pkg::CLASS_W-1:0]             class_id,
  input  logic signed [ncbim_pkg::COORD_BITS-1:0]   left_x,
  input  logic signed [ncbim_pkg::COORD_BITS-1:0]   top_y,
  input  logic signed [ncbim_pkg::COORD_BITS-1:0]   right_x,
  input  logic signed [ncbim_pkg::COORD_BITS-1:0]   bottom_y,
  input  logic [ncbim_pkg::CENTER_W-1:0]            center_x,
  input  logic [ncbim_pkg::CENTER_W-1:0]            center_y,
  output logic                                      result_valid,
  input  logic                                      result_stall,
  output logic                                      match_found,
  output logic [ncbim_pkg::CLASS_W-1:0]             matched_class,
  output logic [ncbim_pkg::IOU_W-1:0]               iou_fraction,
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [ncbim_pkg::APB_ADDR_W-1:0]          paddr,
  input  logic [ncbim_pkg::APB_DATA_W-1:0]          pwdata,
  output logic [ncbim_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                      pready
);
  import ncbim_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_EDGE  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_UNION = 8'b0001_0000,
    S_CHECK = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  localparam logic [1:0] MUL_OVERLAP = 2'd0;
  localparam logic [1:0] MUL_AREA_G  = 2'd1;
  localparam logic [1:0] MUL_AREA_D  = 2'd2;

  state_t state;

  logic [LIMIT_W-1:0] limit;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] scan_idx;
  logic               rd_valid;

  logic [CORNER_W-1:0] corners_mem [MAX_TRUTH_BOXES];
  logic [TAG_W-1:0]    tag_mem     [MAX_TRUTH_BOXES];
  logic [CORNER_W-1:0] rd_corners;
  logic [TAG_W-1:0]    rd_tag;

  logic signed [COORD_BITS-1:0] det_lx, det_ty, det_rx, det_by;
  logic [CENTER_W-1:0]          det_cx, det_cy;

  logic [LIMIT_W-1:0]           best_dist;
  logic                         found;
  logic [CLASS_W-1:0]           best_cls;
  logic signed [COORD_BITS-1:0] best_lx, best_ty, best_rx, best_by;

  logic signed [DIFF_W-1:0] ov_w, ov_h, g_dx, g_dy, d_dx, d_dy;
  logic [1:0]               mul_cnt;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] overlap, area_g, area_d;
  logic signed [UNI_W-1:0]  uni;
  logic [UNI_W-1:0]         rem;
  logic [UNI_W-1:0]         rem2;
  logic [QCNT_W-1:0]        qcnt;
  logic [IOU_W-1:0]         quot;

  logic signed [COORD_BITS-1:0] rd_lx, rd_ty, rd_rx, rd_by;
  logic [CENTER_W-1:0]          rd_cx, rd_cy;
  logic [CLASS_W-1:0]           rd_cls;
  logic [CENTER_W-1:0]          dx, dy;
  logic [DIST_W-1:0]            center_dist;
  logic                         accept, cfg_write;

  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready && (paddr[2] == REG_SEL_LIMIT);
  assign prdata     = (paddr[2] == REG_SEL_LIMIT) ? APB_DATA_W'(limit) : '0;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  assign {rd_lx, rd_ty, rd_rx, rd_by} = rd_corners;
  assign {rd_cx, rd_cy, rd_cls}       = rd_tag;

  assign dx          = (rd_cx >= det_cx) ? rd_cx - det_cx : det_cx - rd_cx;
  assign dy          = (rd_cy >= det_cy) ? rd_cy - det_cy : det_cy - rd_cy;
  assign center_dist = DIST_W'(dx) + DIST_W'(dy);

  always_comb begin
    case (mul_cnt)
      MUL_OVERLAP: begin
        mul_a = ov_w;
        mul_b = ov_h;
      end
      MUL_AREA_G: begin
        mul_a = g_dx;
        mul_b = g_dy;
      end
      default: begin
        mul_a = d_dx;
        mul_b = d_dy;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rem2 = {rem[UNI_W-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (accept && operation == OP_LOAD && count < COUNT_W'(MAX_TRUTH_BOXES)) begin
      corners_mem[count[IDX_W-1:0]] <= {left_x, top_y, right_x, bottom_y};
      tag_mem[count[IDX_W-1:0]]     <= {center_x, center_y, class_id};
    end
    rd_corners <= corners_mem[scan_idx[IDX_W-1:0]];
    rd_tag     <= tag_mem[scan_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      limit <= pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_CLEAR: count <= '0;
              OP_LOAD: begin
                if (count < COUNT_W'(MAX_TRUTH_BOXES)) begin
                  count <= count + 1'b1;
                end
              end
              OP_MATCH: begin
                det_lx    <= left_x;
                det_ty    <= top_y;
                det_rx    <= right_x;
                det_by    <= bottom_y;
                det_cx    <= center_x;
                det_cy    <= center_y;
                best_dist <= limit;
                found     <= 1'b0;
                scan_idx  <= '0;
                rd_valid  <= 1'b0;
                state     <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_idx < count) begin
            scan_idx <= scan_idx + 1'b1;
            rd_valid <= 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
          if (rd_valid && LIMIT_W'(center_dist) < best_dist) begin
            best_dist <= LIMIT_W'(center_dist);
            found     <= 1'b1;
            best_cls  <= rd_cls;
            best_lx   <= rd_lx;
            best_ty   <= rd_ty;
            best_rx   <= rd_rx;
            best_by   <= rd_by;
          end
          if (scan_idx >= count && !rd_valid) begin
            quot  <= '0;
            state <= found ? S_EDGE : S_DONE;
          end
        end
        S_EDGE: begin
          ov_w    <= DIFF_W'((best_rx < det_rx) ? best_rx : det_rx)
                   - DIFF_W'((best_lx > det_lx) ? best_lx : det_lx);
          ov_h    <= DIFF_W'((best_by < det_by) ? best_by : det_by)
                   - DIFF_W'((best_ty > det_ty) ? best_ty : det_ty);
          g_dx    <= DIFF_W'(best_rx) - DIFF_W'(best_lx);
          g_dy    <= DIFF_W'(best_by) - DIFF_W'(best_ty);
          d_dx    <= DIFF_W'(det_rx) - DIFF_W'(det_lx);
          d_dy    <= DIFF_W'(det_by) - DIFF_W'(det_ty);
          mul_cnt <= MUL_OVERLAP;
          state   <= S_MUL;
        end
        S_MUL: begin
          case (mul_cnt)
            MUL_OVERLAP: begin
              overlap <= (ov_w < 0 || ov_h < 0) ? '0 : prod;
              mul_cnt <= MUL_AREA_G;
            end
            MUL_AREA_G: begin
              area_g  <= prod;
              mul_cnt <= MUL_AREA_D;
            end
            default: begin
              area_d <= prod;
              state  <= S_UNION;
            end
          endcase
        end
        S_UNION: begin
          uni   <= UNI_W'(area_g) + UNI_W'(area_d) - UNI_W'(overlap);
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (uni <= 0) begin
            quot  <= '0;
            state <= S_DONE;
          end else if (UNI_W'(overlap) >= uni) begin
            quot  <= IOU_MAX;
            state <= S_DONE;
          end else begin
            rem   <= UNI_W'(overlap);
            qcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= $unsigned(uni)) begin
            rem  <= rem2 - $unsigned(uni);
            quot <= {quot[IOU_W-2:0], 1'b1};
          end else begin
            rem  <= rem2;
            quot <= {quot[IOU_W-2:0], 1'b0};
          end
          qcnt <= qcnt + 1'b1;
          if (qcnt == QCNT_W'(IOU_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid  <= 1'b1;
            match_found   <= found;
            matched_class <= found ? best_cls : '0;
            iou_fraction  <= found ? quot : '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/ncbim_checker.sv
`timescale 1ns / 1ps
`include "nearest_center_box_iou_match_defines.svh"
module ncbim_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_stall,
  input logic [1:0]                    operation,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic                          match_found,
  input logic [ncbim_pkg::CLASS_W-1:0] matched_class,
  input logic [ncbim_pkg::IOU_W-1:0]   iou_fraction
);
  import ncbim_pkg::*;

  `NCBIM_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid, "result item dropped while stalled")
  `NCBIM_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(match_found) && $stable(matched_class) && $stable(iou_fraction), "stalled result item changed")
  `NCBIM_ASSERT_SAME(a_miss_zero, result_valid && !match_found, matched_class == '0 && iou_fraction == '0, "miss carries nonzero class or fraction")
  `NCBIM_ASSERT_NEXT(a_match_busy, item_valid && !item_stall && operation == OP_MATCH, item_stall, "input open right after a match item")

endmodule

bind nearest_center_box_iou_match ncbim_checker u_ncbim_checker (.*);

### dv/ncbim_match_checker.sv
`timescale 1ns / 1ps
module ncbim_match_checker
  import ncbim_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  logic                         item_stall,
  input  logic [1:0]                   operation,
  input  logic [CLASS_W-1:0]           class_id,
  input  logic signed [COORD_BITS-1:0] left_x,
  input  logic signed [COORD_BITS-1:0] top_y,
  input  logic signed [COORD_BITS-1:0] right_x,
  input  logic signed [COORD_BITS-1:0] bottom_y,
  input  logic [CENTER_W-1:0]          center_x,
  input  logic [CENTER_W-1:0]          center_y,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic                         match_found,
  input  logic [CLASS_W-1:0]           matched_class,
  input  logic [IOU_W-1:0]             iou_fraction,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_W-1:0]        paddr,
  input  logic [APB_DATA_W-1:0]        pwdata,
  input  logic                         pready,
  output int                           mismatches,
  output int                           outstanding
);

  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = APB_ADDR_W'(4 * REG_SEL_LIMIT);

  typedef struct {
    logic               found;
    logic [CLASS_W-1:0] cls;
    logic [IOU_W-1:0]   iou;
  } match_result_t;

  logic signed [COORD_BITS-1:0] gt_left   [MAX_TRUTH_BOXES];
  logic signed [COORD_BITS-1:0] gt_top    [MAX_TRUTH_BOXES];
  logic signed [COORD_BITS-1:0] gt_right  [MAX_TRUTH_BOXES];
  logic signed [COORD_BITS-1:0] gt_bottom [MAX_TRUTH_BOXES];
  logic [CENTER_W-1:0]          gt_cx     [MAX_TRUTH_BOXES];
  logic [CENTER_W-1:0]          gt_cy     [MAX_TRUTH_BOXES];
  logic [CLASS_W-1:0]           gt_class  [MAX_TRUTH_BOXES];
  int                           gt_count;
  logic [LIMIT_W-1:0]           distance_limit;
  match_result_t                awaited_results[$];
  int                           fail_total;

  function automatic logic [IOU_W-1:0] iou_q16(input longint gl, gt, gr, gb,
                                               input longint dl, dt, dr, db);
    longint w, h, ov, area_g, area_d, uni, q;
    w = ((gr < dr) ? gr : dr) - ((gl > dl) ? gl : dl);
    h = ((gb < db) ? gb : db) - ((gt > dt) ? gt : dt);
    ov = (w < 0 || h < 0) ? 0 : w * h;
    area_g = (gr - gl) * (gb - gt);
    area_d = (dr - dl) * (db - dt);
    uni = area_g + area_d - ov;
    if (uni <= 0) return '0;
    q = (ov * 65536) / uni;
    return (q > 65535) ? IOU_MAX : IOU_W'(q);
  endfunction

  function automatic match_result_t predict_match(
    input logic [CENTER_W-1:0] cx, cy,
    input logic signed [COORD_BITS-1:0] lx, ty, rx, by);
    match_result_t r;
    int best_dist, best_idx, dx, dy;
    r.found = 1'b0;
    r.cls = '0;
    r.iou = '0;
    best_dist = int'(distance_limit);
    best_idx = 0;
    for (int i = 0; i < gt_count; i++) begin
      dx = int'(gt_cx[i]) - int'(cx);
      dy = int'(gt_cy[i]) - int'(cy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx + dy < best_dist) begin
        best_dist = dx + dy;
        best_idx = i;
        r.found = 1'b1;
      end
    end
    if (r.found) begin
      r.cls = gt_class[best_idx];
      r.iou = iou_q16(gt_left[best_idx], gt_top[best_idx], gt_right[best_idx],
                      gt_bottom[best_idx], lx, ty, rx, by);
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    match_result_t want;
    if (rst) begin
      gt_count = 0;
      distance_limit = LIMIT_RESET;
      awaited_results.delete();
      fail_total = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
        distance_limit = pwdata[LIMIT_W-1:0];
      if (result_valid && !result_stall) begin
        if (awaited_results.size() == 0) begin
          $error("result with no match item pending: found %0d class %0d iou %0d",
                 match_found, matched_class, iou_fraction);
          fail_total++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("match_found", want.found, match_found);
          compare_field("matched_class", want.cls, matched_class);
          compare_field("iou_fraction", want.iou, iou_fraction);
        end
      end
      if (item_valid && !item_stall) begin
        case (operation)
          OP_CLEAR: gt_count = 0;
          OP_LOAD: begin
            if (gt_count < MAX_TRUTH_BOXES) begin
              gt_left[gt_count]   = left_x;
              gt_top[gt_count]    = top_y;
              gt_right[gt_count]  = right_x;
              gt_bottom[gt_count] = bottom_y;
              gt_cx[gt_count]     = center_x;
              gt_cy[gt_count]     = center_y;
              gt_class[gt_count]  = class_id;
              gt_count++;
            end
          end
          OP_MATCH: begin
            want = predict_match(center_x, center_y, left_x, top_y, right_x, bottom_y);
            awaited_results = {awaited_results, want};
          end
          default: ;
        endcase
      end
    end
    mismatches <= fail_total;
    outstanding <= awaited_results.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
module tb;
  import ncbim_pkg::*;

  localparam logic [1:0]            OP_RESERVED   = 2'd3;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR    = APB_ADDR_W'(4 * REG_SEL_LIMIT);
  localparam int                    COORD_MIN     = -(2 ** (COORD_BITS - 1));
  localparam int                    COORD_MAX     = 2 ** (COORD_BITS - 1) - 1;
  localparam int                    CENTER_MAX    = 2 ** CENTER_W - 1;
  localparam int                    HOLD_CYCLES   = 400;
  localparam int                    IDLE_LIMIT    = 4000;
  localparam int                    SETTLE_CYCLES = 120;
  localparam int                    PHASE_ITEMS   = 215;

  typedef struct {
    logic [1:0]                   op;
    logic [CLASS_W-1:0]           cls;
    logic signed [COORD_BITS-1:0] lx;
    logic signed [COORD_BITS-1:0] ty;
    logic signed [COORD_BITS-1:0] rx;
    logic signed [COORD_BITS-1:0] by;
    logic [CENTER_W-1:0]          cx;
    logic [CENTER_W-1:0]          cy;
  } box_item_t;

  logic                         clk          = 1'b0;
  logic                         rst          = 1'b1;
  logic                         item_valid   = 1'b0;
  logic                         item_stall;
  logic [1:0]                   operation    = OP_CLEAR;
  logic [CLASS_W-1:0]           class_id     = '0;
  logic signed [COORD_BITS-1:0] left_x       = '0;
  logic signed [COORD_BITS-1:0] top_y        = '0;
  logic signed [COORD_BITS-1:0] right_x      = '0;
  logic signed [COORD_BITS-1:0] bottom_y     = '0;
  logic [CENTER_W-1:0]          center_x     = '0;
  logic [CENTER_W-1:0]          center_y     = '0;
  logic                         result_valid;
  logic                         result_stall = 1'b0;
  logic                         match_found;
  logic [CLASS_W-1:0]           matched_class;
  logic [IOU_W-1:0]             iou_fraction;
  logic                         psel         = 1'b0;
  logic                         penable      = 1'b0;
  logic                         pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0]        paddr        = '0;
  logic [APB_DATA_W-1:0]        pwdata       = '0;
  logic [APB_DATA_W-1:0]        prdata;
  logic                         pready;

  int        mismatches;
  int        outstanding;
  int        idle_run = 0;
  int        items_sent = 0;
  int        gen_count = 0;
  int        sender_calm = 0;
  bit        tail_quiet = 1'b0;
  bit        hold_request = 1'b0;
  box_item_t gen_table[MAX_TRUTH_BOXES];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nearest_center_box_iou_match u_dut (
    .clk, .rst, .item_valid, .item_stall, .operation, .class_id, .left_x, .top_y,
    .right_x, .bottom_y, .center_x, .center_y, .result_valid, .result_stall,
    .match_found, .matched_class, .iou_fraction, .psel, .penable, .pwrite, .paddr,
    .pwdata, .prdata, .pready
  );

  ncbim_match_checker u_checker (
    .clk, .rst, .item_valid, .item_stall, .operation, .class_id, .left_x, .top_y,
    .right_x, .bottom_y, .center_x, .center_y, .result_valid, .result_stall,
    .match_found, .matched_class, .iou_fraction, .psel, .penable, .pwrite, .paddr,
    .pwdata, .pready, .mismatches, .outstanding
  );

  wire activity = (item_valid && !item_stall) || (result_valid && !result_stall) ||
                  (psel && penable);

  always @(posedge clk) idle_run <= (rst || activity) ? 0 : idle_run + 1;

  initial begin
    wait (idle_run >= IDLE_LIMIT);
    $display("** nearest_center_box_iou_match: FAILED **");
    $finish;
  end

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return COORD_BITS'(v);
  endfunction

  function automatic logic [CENTER_W-1:0] clamp_center(input int v);
    if (v < 0) v = 0;
    if (v > CENTER_MAX) v = CENTER_MAX;
    return CENTER_W'(v);
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic box_item_t random_box(input logic [1:0] op);
    box_item_t b;
    int cx, cy, hw, hh;
    b.op = op;
    b.cls = CLASS_W'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      // coarse grid: centers collide, so ties happen
      cx = 64 * $urandom_range(0, 8);
      cy = 64 * $urandom_range(0, 8);
    end else begin
      cx = $urandom_range(0, CENTER_MAX);
      cy = $urandom_range(0, CENTER_MAX);
    end
    b.cx = CENTER_W'(cx);
    b.cy = CENTER_W'(cy);
    if ($urandom_range(0, 7) == 0) begin
      b.lx = COORD_BITS'($urandom_range(0, 2 ** COORD_BITS - 1));
      b.ty = COORD_BITS'($urandom_range(0, 2 ** COORD_BITS - 1));
      b.rx = COORD_BITS'($urandom_range(0, 2 ** COORD_BITS - 1));
      b.by = COORD_BITS'($urandom_range(0, 2 ** COORD_BITS - 1));
    end else begin
      hw = $urandom_range(0, 400);
      hh = $urandom_range(0, 400);
      b.lx = clamp_coord(cx - hw);
      b.rx = clamp_coord(cx + hw);
      b.ty = clamp_coord(cy - hh);
      b.by = clamp_coord(cy + hh);
    end
    return b;
  endfunction

  function automatic box_item_t detection_box();
    box_item_t d;
    int reach, spread;
    if (gen_count == 0 || $urandom_range(0, 7) == 0) return random_box(OP_MATCH);
    d = gen_table[$urandom_range(0, gen_count - 1)];
    d.op = OP_MATCH;
    d.cls = CLASS_W'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: reach = 0;
      1: reach = 3;
      2: reach = 40;
      default: reach = 600;
    endcase
    d.cx = clamp_center(int'(d.cx) + jitter(reach));
    d.cy = clamp_center(int'(d.cy) + jitter(reach));
    if ($urandom_range(0, 5) != 0) begin
      spread = $urandom_range(0, 60);
      d.lx = clamp_coord(int'(d.lx) + jitter(spread));
      d.ty = clamp_coord(int'(d.ty) + jitter(spread));
      d.rx = clamp_coord(int'(d.rx) + jitter(spread));
      d.by = clamp_coord(int'(d.by) + jitter(spread));
    end
    return d;
  endfunction

  task automatic issue(input box_item_t it);
    if (!tail_quiet) begin
      if (sender_calm > 0) begin
        sender_calm--;
      end else if ($urandom_range(0, 24) == 0) begin
        sender_calm = $urandom_range(20, 60);
      end else if ($urandom_range(0, 3) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
    item_valid <= 1'b1;
    operation  <= it.op;
    class_id   <= it.cls;
    left_x     <= it.lx;
    top_y      <= it.ty;
    right_x    <= it.rx;
    bottom_y   <= it.by;
    center_x   <= it.cx;
    center_y   <= it.cy;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    case (it.op)
      OP_CLEAR: begin
        gen_count = 0;
        items_sent++;
      end
      OP_LOAD: begin
        if (gen_count < MAX_TRUTH_BOXES) begin
          gen_table[gen_count] = it;
          gen_count++;
          items_sent++;
        end
      end
      OP_MATCH: items_sent++;
      default: ;
    endcase
  endtask

  task automatic put(input logic [1:0] op, input int cls, lx, ty, rx, by, cx, cy);
    box_item_t b;
    b.op = op;
    b.cls = CLASS_W'(cls);
    b.lx = COORD_BITS'(lx);
    b.ty = COORD_BITS'(ty);
    b.rx = COORD_BITS'(rx);
    b.by = COORD_BITS'(by);
    b.cx = CENTER_W'(cx);
    b.cy = CENTER_W'(cy);
    issue(b);
  endtask

  task automatic wait_for_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] value, input int quota);
    int stop_at, n_loads, n_matches;
    wait_for_drain();
    write_limit(value);
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) != 0) issue(random_box(OP_CLEAR));
      n_loads = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                              : $urandom_range(0, 8);
      repeat (n_loads) issue(random_box(OP_LOAD));
      n_matches = $urandom_range(1, 6);
      repeat (n_matches) issue(detection_box());
      if ($urandom_range(0, 9) == 0) issue(random_box(2'($urandom_range(0, 3))));
    end
  endtask

  initial begin
    int calm;
    calm = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!tail_quiet && !rst) begin
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 19) == 0) begin
          calm = $urandom_range(30, 150);
        end else if ($urandom_range(0, 3) == 0) begin
          result_stall <= 1'b1;
          repeat ($urandom_range(1, 3)) @(posedge clk);
          result_stall <= 1'b0;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    put(OP_MATCH, 165, 0, 0, 10, 10, 5, 5);
    put(OP_LOAD, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0);
    put(OP_MATCH, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0);
    put(OP_LOAD, 255, 4000, 4000, COORD_MAX, COORD_MAX, CENTER_MAX, CENTER_MAX);
    put(OP_MATCH, 0, COORD_MIN, COORD_MIN, -4000, -4000, CENTER_MAX, CENTER_MAX);
    put(OP_LOAD, 7, 0, 0, 0, 0, 2048, 2048);
    put(OP_MATCH, 0, 0, 0, 0, 0, 2048, 2048);
    put(OP_LOAD, 9, 100, -100, -100, 100, 1024, 1024);
    put(OP_MATCH, 0, 100, -100, -100, 100, 1024, 1024);
    put(OP_LOAD, 10, -50, -50, 50, 50, 3000, 100);
    put(OP_LOAD, 11, -60, -60, 60, 60, 3000, 100);
    put(OP_MATCH, 0, -55, -55, 55, 55, 3001, 101);
    put(OP_RESERVED, 255, COORD_MAX, COORD_MIN, -1, 1, CENTER_MAX, 0);
    put(OP_MATCH, 0, 0, 0, 1000, 1000, 10, 10);
    put(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    put(OP_MATCH, 0, 0, 0, 1000, 1000, 0, 0);
    put(OP_LOAD, 200, -10, -10, 10, 10, 1, 1);
    put(OP_MATCH, 0, -10, -10, 10, 10, CENTER_MAX, CENTER_MAX);
    put(OP_MATCH, 0, 10, -10, 30, 10, 1, 1);

    hold_request = 1'b1;
    run_phase(LIMIT_W'(16383), PHASE_ITEMS);
    run_phase(LIMIT_W'(1), PHASE_ITEMS);
    run_phase(LIMIT_W'(0), PHASE_ITEMS);
    run_phase(LIMIT_W'(40), PHASE_ITEMS);
    run_phase(LIMIT_W'($urandom_range(1, 16383)), PHASE_ITEMS);
    tail_quiet = 1'b1;
    run_phase(LIMIT_W'(2000), PHASE_ITEMS);

    wait_for_drain();
    if (mismatches == 0)
      $display("** nearest_center_box_iou_match: PASSED **");
    else
      $display("** nearest_center_box_iou_match: FAILED **");
    $finish;
  end

endmodule
